// File: src/mme_pkg.sv
// Shared types, constants and term tables for the multipole monomial expansion block.
`default_nettype none

package mme_pkg;

  localparam int ORDER_LIMIT = 6;
  localparam int STORE_DEPTH = (ORDER_LIMIT + 1) * (ORDER_LIMIT + 2) * (ORDER_LIMIT + 3) / 6;
  localparam int RESULT_PORT = 64;
  localparam int CNT_W = 7;
  localparam int ORD_W = 3;

  localparam logic [63:0] ONE_Q56   = 64'h0100_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    axis_e            axis;
    logic [CNT_W-1:0] parent;
  } term_info_t;

  typedef term_info_t [STORE_DEPTH-1:0] term_tbl_t;

  typedef struct packed {
    logic [31:0]      strain;
    logic [31:0]      radius;
    logic [31:0]      rel_x;
    logic [31:0]      rel_y;
    logic [31:0]      rel_z;
    logic [CNT_W-1:0] n_terms;
  } item_t;

  localparam logic [CNT_W-1:0] COUNT_TBL [ORDER_LIMIT+1] = '{
    7'd1, 7'd4, 7'd10, 7'd20, 7'd35, 7'd56, 7'd64
  };

  function automatic int tetra(int d);
    return d * (d + 1) * (d + 2) / 6;
  endfunction

  function automatic int tri_num(int d);
    return d * (d + 1) / 2;
  endfunction

  function automatic int term_cap(int ord);
    int t;
    t = tetra(ord + 1);
    if (t > RESULT_PORT) t = RESULT_PORT;
    return t;
  endfunction

  function automatic term_tbl_t build_term_tbl();
    term_tbl_t tbl;
    int        idx;
    int        pidx;
    int        pa;
    int        pb;
    int        pd;
    axis_e     ax;
    tbl = '0;
    for (int d = 1; d <= ORDER_LIMIT; d++) begin
      for (int a = d; a >= 0; a--) begin
        for (int b = d - a; b >= 0; b--) begin
          pa = a;
          pb = b;
          pd = d - 1;
          if (a > 0) begin
            ax = AXIS_X;
            pa = a - 1;
          end else if (b > 0) begin
            ax = AXIS_Y;
            pb = b - 1;
          end else begin
            ax = AXIS_Z;
          end
          idx  = tetra(d) + tri_num(d - a) + (d - a - b);
          pidx = tetra(pd) + tri_num(pd - pa) + (pd - pa - pb);
          tbl[idx].axis   = ax;
          tbl[idx].parent = CNT_W'(pidx);
        end
      end
    end
    return tbl;
  endfunction

  // Axis and parent term of every monomial in emission order.
  localparam term_tbl_t TERM_TBL = build_term_tbl();

endpackage

`default_nettype wire

// File: src/mme_front.sv
// Front end: order register, relative vector and term count for each accepted word.
`default_nettype none

module mme_front #(
  parameter int MAX_ORDER = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [2:0]               cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [31:0]              strain_i,
  input  wire logic [31:0]              radius_i,
  input  wire logic [31:0]              pos_x_i,
  input  wire logic [31:0]              pos_y_i,
  input  wire logic [31:0]              pos_z_i,
  input  wire logic [31:0]              ctr_x_i,
  input  wire logic [31:0]              ctr_y_i,
  input  wire logic [31:0]              ctr_z_i,
  output logic                          push_valid_o,
  input  wire logic                     push_ready_i,
  output mme_pkg::item_t                push_item_o
);
  import mme_pkg::*;

  localparam logic [ORD_W-1:0] MaxOrd = ORD_W'(MAX_ORDER);

  logic [ORD_W-1:0] order_q;
  logic [ORD_W-1:0] order_eff;

  function automatic logic [31:0] sat_diff(logic [31:0] ctr, logic [31:0] pos);
    logic [32:0] diff;
    diff = {ctr[31], ctr} - {pos[31], pos};
    if (diff[32] != diff[31]) begin
      return diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return diff[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  assign order_eff = (order_q > MaxOrd) ? MaxOrd : order_q;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_item_o.strain  = strain_i;
    push_item_o.radius  = radius_i;
    push_item_o.rel_x   = sat_diff(ctr_x_i, pos_x_i);
    push_item_o.rel_y   = sat_diff(ctr_y_i, pos_y_i);
    push_item_o.rel_z   = sat_diff(ctr_z_i, pos_z_i);
    push_item_o.n_terms = COUNT_TBL[order_eff];
  end

endmodule

`default_nettype wire

// File: src/mme_queue.sv
// Two-entry queue that decouples the front end from the arithmetic back end.
`default_nettype none

module mme_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire mme_pkg::item_t push_item_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output mme_pkg::item_t      pop_item_o
);
  import mme_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: src/mme_back.sv
// Back end: shared 32x32 multiplier sequencer, monomial memory and output register.
`default_nettype none

module mme_back #(
  parameter int MAX_ORDER = 6
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire mme_pkg::item_t item_i,
  output logic                item_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [63:0]         coeff_o,
  output logic [6:0]          coeff_index_o,
  output logic                last_coeff_o
);
  import mme_pkg::*;

  localparam int MemDepth = term_cap(MAX_ORDER);
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  localparam logic [127:0] HALF_30 = 128'(1) << 29;
  localparam logic [127:0] HALF_47 = 128'(1) << 46;
  localparam logic [127:0] HALF_56 = 128'(1) << 55;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_SR,
    OP_R2,
    OP_SCALE,
    OP_MONO,
    OP_COEFF
  } op_e;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  state_e           state_q;
  op_e              op_q;
  logic [1:0]       pp_q;
  logic [127:0]     acc_q;
  logic [63:0]      opa_q;
  logic [63:0]      opb_q;
  logic             neg_q;
  logic [63:0]      tmp_q;
  smag_t            scale_q;
  item_t            item_q;
  logic [CNT_W-1:0] k_q;
  smag_t            rd_q;
  smag_t            mem_q [MemDepth];
  logic             out_valid_q;
  logic [63:0]      coeff_q;
  logic [6:0]       index_q;
  logic             last_q;

  term_info_t       cur_info;
  logic [31:0]      rel_sel;
  logic [31:0]      rel_mag;
  logic [31:0]      in_strain_mag;
  logic [31:0]      a_half;
  logic [63:0]      b_full;
  logic [31:0]      b_half;
  logic [63:0]      prod;
  logic [127:0]     pp_shifted;
  logic [127:0]     acc_sum;
  logic [1:0]       last_pp;
  logic [127:0]     q_shift;
  logic [63:0]      limit;
  logic [63:0]      sat_mag;
  logic             fin_neg;
  logic [63:0]      coeff_val;
  logic             out_free;
  logic             out_load;
  logic             last_term;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  smag_t            wr_data;

  assign cur_info = TERM_TBL[k_q];

  always_comb begin
    case (cur_info.axis)
      AXIS_X:  rel_sel = item_q.rel_x;
      AXIS_Y:  rel_sel = item_q.rel_y;
      default: rel_sel = item_q.rel_z;
    endcase
  end

  assign rel_mag       = rel_sel[31] ? (~rel_sel + 32'd1) : rel_sel;
  assign in_strain_mag = item_i.strain[31] ? (~item_i.strain + 32'd1) : item_i.strain;

  assign a_half = pp_q[1] ? opa_q[63:32] : opa_q[31:0];
  assign b_full = (op_q == OP_MONO) ? rd_q.mag : opb_q;
  assign b_half = pp_q[0] ? b_full[63:32] : b_full[31:0];
  assign prod   = 64'(a_half) * 64'(b_half);

  always_comb begin
    unique case ({1'b0, pp_q[1]} + {1'b0, pp_q[0]})
      2'd0:    pp_shifted = {64'd0, prod};
      2'd1:    pp_shifted = {32'd0, prod, 32'd0};
      default: pp_shifted = {prod, 64'd0};
    endcase
  end

  assign acc_sum = acc_q + pp_shifted;

  always_comb begin
    case (op_q)
      OP_SR, OP_R2: last_pp = 2'd0;
      OP_MONO:      last_pp = 2'd1;
      default:      last_pp = 2'd3;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_SCALE: q_shift = acc_q >> 47;
      OP_MONO:  q_shift = acc_q >> 30;
      default:  q_shift = acc_q >> 56;
    endcase
  end

  assign fin_neg   = (op_q == OP_MONO) ? (neg_q ^ rd_q.neg) : neg_q;
  assign limit     = fin_neg ? NEG_LIMIT : POS_LIMIT;
  assign sat_mag   = ((|q_shift[127:64]) || (q_shift[63:0] > limit)) ? limit : q_shift[63:0];
  assign coeff_val = fin_neg ? (~sat_mag + 64'd1) : sat_mag;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == ST_FIN) && (op_q == OP_COEFF) && out_free;
  assign last_term = ((k_q + 7'd1) == item_q.n_terms);

  assign wr_en   = (state_q == ST_FIN) && ((op_q == OP_SCALE) || (op_q == OP_MONO));
  assign wr_addr = (op_q == OP_SCALE) ? '0 : k_q[AddrW-1:0];
  always_comb begin
    if (op_q == OP_SCALE) begin
      wr_data = '{neg: 1'b0, mag: ONE_Q56};
    end else begin
      wr_data = '{neg: fin_neg, mag: sat_mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[cur_info.parent[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SR;
      pp_q        <= '0;
      acc_q       <= '0;
      opa_q       <= '0;
      opb_q       <= '0;
      neg_q       <= 1'b0;
      tmp_q       <= '0;
      scale_q     <= '0;
      item_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      coeff_q     <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            item_q  <= item_i;
            op_q    <= OP_SR;
            opa_q   <= {32'd0, in_strain_mag};
            opb_q   <= {32'd0, item_i.radius};
            acc_q   <= '0;
            pp_q    <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_READ: begin
          op_q    <= OP_MONO;
          opa_q   <= {32'd0, rel_mag};
          neg_q   <= rel_sel[31];
          acc_q   <= HALF_30;
          pp_q    <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          acc_q <= acc_sum;
          if (pp_q == last_pp) begin
            state_q <= ST_FIN;
          end else begin
            pp_q <= pp_q + 2'd1;
          end
        end
        ST_FIN: begin
          case (op_q)
            OP_SR: begin
              tmp_q   <= acc_q[63:0];
              op_q    <= OP_R2;
              opa_q   <= {32'd0, item_q.radius};
              opb_q   <= {32'd0, item_q.radius};
              acc_q   <= '0;
              pp_q    <= '0;
              state_q <= ST_MUL;
            end
            OP_R2: begin
              op_q    <= OP_SCALE;
              opa_q   <= tmp_q;
              opb_q   <= acc_q[63:0];
              neg_q   <= item_q.strain[31];
              acc_q   <= HALF_47;
              pp_q    <= '0;
              state_q <= ST_MUL;
            end
            OP_SCALE: begin
              scale_q <= '{neg: fin_neg, mag: sat_mag};
              k_q     <= '0;
              op_q    <= OP_COEFF;
              opa_q   <= sat_mag;
              opb_q   <= ONE_Q56;
              neg_q   <= fin_neg;
              acc_q   <= HALF_56;
              pp_q    <= '0;
              state_q <= ST_MUL;
            end
            OP_MONO: begin
              op_q    <= OP_COEFF;
              opa_q   <= scale_q.mag;
              opb_q   <= sat_mag;
              neg_q   <= scale_q.neg ^ fin_neg;
              acc_q   <= HALF_56;
              pp_q    <= '0;
              state_q <= ST_MUL;
            end
            default: begin
              if (out_free) begin
                coeff_q     <= coeff_val;
                index_q     <= k_q;
                last_q      <= last_term;
                if (last_term) begin
                  state_q <= ST_IDLE;
                end else begin
                  k_q     <= k_q + 7'd1;
                  state_q <= ST_READ;
                end
              end
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign item_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign coeff_o       = coeff_q;
  assign coeff_index_o = index_q;
  assign last_coeff_o  = last_q;

endmodule

`default_nettype wire

// File: src/multipole_monomial_expansion.sv
// Top level of the Cartesian multipole monomial expansion block.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    strain, radius, pos_x/y/z, ctr_x/y/z
//   out      output     out_valid_o / out_ready_i  coeff, coeff_index, last_coeff
//   cfg      input      cfg_we_i                   cfg_wdata_i (expansion order)
//
// One input word yields n = min(terms up to the order, 64) output words and occupies the
// back end, in which the single shared 32x32 multiplier forms the scale, every monomial and
// every coefficient from 32-bit partial products.
// A two-entry queue lets the front end take two more words while the back end works.
// A stalled output register holds the back end; the front end keeps filling the queue.
// Reset is asynchronous and active low and clears all control state and the order.
`default_nettype none

module multipole_monomial_expansion #(
  parameter int MAX_ORDER = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] strain_i,
  input  wire logic [31:0] radius_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] ctr_x_i,
  input  wire logic [31:0] ctr_y_i,
  input  wire logic [31:0] ctr_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      coeff_o,
  output logic [6:0]       coeff_index_o,
  output logic             last_coeff_o
);
  import mme_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  mme_front #(
    .MAX_ORDER(MAX_ORDER)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .strain_i    (strain_i),
    .radius_i    (radius_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .ctr_x_i     (ctr_x_i),
    .ctr_y_i     (ctr_y_i),
    .ctr_z_i     (ctr_z_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  mme_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  mme_back #(
    .MAX_ORDER(MAX_ORDER)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coeff_o      (coeff_o),
    .coeff_index_o(coeff_index_o),
    .last_coeff_o (last_coeff_o)
  );

endmodule

`default_nettype wire

// File: src/mme_chk.sv
// Port-level checker for the multipole monomial expansion block and its bind.
`default_nettype none

module mme_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] coeff_o,
  input wire logic [6:0]  coeff_index_o,
  input wire logic        last_coeff_o
);

  logic [6:0] exp_idx_q;
  logic [2:0] pend_q;
  logic       in_acc;
  logic       out_last_acc;

  assign in_acc       = in_valid_i & in_ready_o;
  assign out_last_acc = out_valid_o & out_ready_i & last_coeff_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
      pend_q    <= '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        exp_idx_q <= last_coeff_o ? 7'd0 : (coeff_index_o + 7'd1);
      end
      unique case ({in_acc, out_last_acc})
        2'b10:   pend_q <= pend_q + 3'd1;
        2'b01:   pend_q <= pend_q - 3'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coeff_o) &&
      $stable(coeff_index_o) && $stable(last_coeff_o))
    else $error("output word changed while stalled");

  // Terms of one input are numbered consecutively from zero.
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coeff_index_o == exp_idx_q)
    else $error("coefficient index out of sequence");

  // The final term of an input closes a complete degree or the result limit.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_coeff_o |-> coeff_index_o == 7'd0 || coeff_index_o == 7'd3 ||
      coeff_index_o == 7'd9 || coeff_index_o == 7'd19 || coeff_index_o == 7'd34 ||
      coeff_index_o == 7'd55 || coeff_index_o == 7'd63)
    else $error("last flag on an index that ends no expansion");

  // No output word appears without an input that is still open.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("output word without an outstanding input");

endmodule

bind multipole_monomial_expansion mme_chk u_mme_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .coeff_o      (coeff_o),
  .coeff_index_o(coeff_index_o),
  .last_coeff_o (last_coeff_o)
);

`default_nettype wire
